// ===== rtl/dte_pkg.sv =====
// dte_pkg: shared constants, types and tables for the dcm to euler attitude block
// no dependencies
`default_nettype none
package dte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int NSTEPS       = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int SQ_STEPS     = 15;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int CW           = 36;   // cordic x/y width
  localparam int ZW           = 34;   // cordic angle width, q2.30
  localparam int SHW          = 5;    // shift-amount width

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [15:0] PITCH_LIM = 16'd12868;
  localparam logic [15:0] ANGLE_LIM = 16'd25736;
  localparam logic [9:0]  ZB_RESET  = 10'd1;

  typedef logic signed [15:0] elem_t;
  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    elem_t m21;
    elem_t m20;
    elem_t m22;
    elem_t m01;
    elem_t m11;
  } in_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic signed [17:0] t;     // clamped m21
    logic signed [17:0] ry;
    logic signed [17:0] rx;
    logic               rzero;
    logic signed [17:0] yy;
    logic signed [17:0] yx;
    logic               yzero;
  } cls_item_t;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
  } out_item_t;

  function automatic ang_t atan_tab(input logic [SHW-1:0] i);
    unique case (i)
      5'd0: atan_tab = 34'h03243F6A8;
      5'd1: atan_tab = 34'h01DAC6705;
      5'd2: atan_tab = 34'h00FADBAFC;
      5'd3: atan_tab = 34'h007F56EA6;
      5'd4: atan_tab = 34'h003FEAB76;
      5'd5: atan_tab = 34'h001FFD55B;
      5'd6: atan_tab = 34'h000FFFAAA;
      5'd7: atan_tab = 34'h0007FFF55;
      5'd8: atan_tab = 34'h0003FFFEA;
      5'd9: atan_tab = 34'h0001FFFFD;
      5'd10: atan_tab = 34'h0000FFFFF;
      5'd11: atan_tab = 34'h00007FFFF;
      5'd12: atan_tab = 34'h00003FFFF;
      5'd13: atan_tab = 34'h00001FFFF;
      5'd14: atan_tab = 34'h00000FFFF;
      5'd15: atan_tab = 34'h000007FFF;
      5'd16: atan_tab = 34'h000003FFF;
      5'd17: atan_tab = 34'h000001FFF;
      5'd18: atan_tab = 34'h000000FFF;
      5'd19: atan_tab = 34'h0000007FF;
      5'd20: atan_tab = 34'h0000003FF;
      5'd21: atan_tab = 34'h0000001FF;
      5'd22: atan_tab = 34'h0000000FF;
      5'd23: atan_tab = 34'h00000007F;
      5'd24: atan_tab = 34'h00000003F;
      5'd25: atan_tab = 34'h00000001F;
      5'd26: atan_tab = 34'h00000000F;
      5'd27: atan_tab = 34'h000000008;
      5'd28: atan_tab = 34'h000000004;
      5'd29: atan_tab = 34'h000000002;
      5'd30: atan_tab = 34'h000000001;
      default: atan_tab = 34'h000000000;
    endcase
  endfunction

  // round q2.30 to q3.13 half away from zero, then saturate
  function automatic logic signed [16:0] to_q13(input ang_t z, input logic [15:0] lim);
    logic [ZW-1:0] m;
    logic [ZW-1:0] r;
    logic [16:0]   q;
    m = z[ZW-1] ? ZW'(-z) : ZW'(z);
    r = (m + ZW'(65536)) >> 17;
    q = (r > ZW'(lim)) ? {1'b0, lim} : r[16:0];
    to_q13 = z[ZW-1] ? -$signed(q) : $signed(q);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dte_if.sv =====
// dte_if: valid/ready channel carrying one item of a given type
// depends on dte_pkg
`default_nettype none
interface dte_in_if;
  import dte_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dte_out_if;
  import dte_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dte_front.sv =====
// dte_front: accepts items, clamps m21, negates arguments and checks dead-band
// depends on dte_pkg
`default_nettype none
module dte_front
  import dte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [9:0] zero_band,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           f_valid,
  input  wire logic      f_ready,
  output cls_item_t      f_data
);

  logic      v_r;
  cls_item_t d_r, d_nxt;

  function automatic logic in_band(input logic signed [17:0] v, input logic [9:0] b);
    logic signed [17:0] bs;
    bs = $signed({8'd0, b});
    in_band = (v >= -bs) && (v <= bs);
  endfunction

  assign in_ready = !v_r || f_ready;
  assign f_valid  = v_r;
  assign f_data   = d_r;

  // classification
  always_comb begin
    logic signed [17:0] t;
    t = 18'(in_data.m21);
    if (t > 18'sd16384) t = 18'sd16384;
    if (t < -18'sd16384) t = -18'sd16384;
    d_nxt.t  = t;
    d_nxt.ry = -18'(in_data.m20);
    d_nxt.rx = 18'(in_data.m22);
    d_nxt.yy = -18'(in_data.m01);
    d_nxt.yx = 18'(in_data.m11);
    d_nxt.rzero = in_band(d_nxt.ry, zero_band) && in_band(d_nxt.rx, zero_band);
    d_nxt.yzero = in_band(d_nxt.yy, zero_band) && in_band(d_nxt.yx, zero_band);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dte_queue.sv =====
// dte_queue: small fifo between front and back
// depends on dte_pkg
`default_nettype none
module dte_queue
  import dte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      w_valid,
  output logic           w_ready,
  input  wire cls_item_t w_data,
  output logic           r_valid,
  input  wire logic      r_ready,
  output cls_item_t      r_data
);

  cls_item_t         mem_r [QDEPTH];
  logic [QAW-1:0]    wp_r, rp_r;
  logic [QAW:0]      cnt_r;

  assign w_ready = cnt_r != (QAW+1)'(QDEPTH);
  assign r_valid = cnt_r != '0;
  assign r_data  = mem_r[rp_r];

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (w_valid && w_ready) wp_r <= wp_r + 1'b1;
      if (r_valid && r_ready) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(w_valid && w_ready) - (QAW+1)'(r_valid && r_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (w_valid && w_ready) mem_r[wp_r] <= w_data;
  end

endmodule
`default_nettype wire

// ===== rtl/dte_back.sv =====
// dte_back: pipelined square root and three vectoring cordics, output register
// depends on dte_pkg
`default_nettype none
module dte_back
  import dte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      b_valid,
  output logic           b_ready,
  input  wire cls_item_t b_data,
  output logic           o_valid,
  input  wire logic      o_ready,
  output out_item_t      o_data
);

  localparam int NS = SQ_STEPS + 1 + NSTEPS + 1; // total stages
  // stage indices: 0..SQ_STEPS sqrt, SQ_STEPS+1 prerotation, then one per cordic step

  logic adv;
  logic [NS-1:0] v_r;

  // sqrt state
  logic [28:0] sq_v_r [SQ_STEPS+1];
  logic [28:0] sq_r_r [SQ_STEPS+1];
  cls_item_t   sq_d_r [SQ_STEPS+1];

  // cordic state: three lanes
  cval_t cx_r [3][NSTEPS+1];
  cval_t cy_r [3][NSTEPS+1];
  ang_t  cz_r [3][NSTEPS+1];
  logic  rz_r [NSTEPS+1];
  logic  yz_r [NSTEPS+1];

  out_item_t o_r;
  logic      ov_r;

  assign b_ready = adv;
  assign adv     = !ov_r || o_ready || !v_r[NS-1];
  assign o_valid = ov_r;
  assign o_data  = o_r;

  // whole pipeline moves together; stalls only when the output is held
  // sqrt stage 0 input: v = 2^28 - t*t, first root bit 2^28 (exact isqrt, digit a stage)
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_d_r[0] <= b_data;
      sq_v_r[0] <= 29'h1000_0000 - 29'(b_data.t * b_data.t);
      sq_r_r[0] <= '0;
      for (int s = 0; s < SQ_STEPS; s++) begin
        logic [28:0] bit_v, rb;
        bit_v = 29'(1) << (28 - 2*s);
        rb = sq_r_r[s] + bit_v;
        if (sq_v_r[s] >= rb) begin
          sq_v_r[s+1] <= sq_v_r[s] - rb;
          sq_r_r[s+1] <= (sq_r_r[s] >> 1) + bit_v;
        end else begin
          sq_v_r[s+1] <= sq_v_r[s];
          sq_r_r[s+1] <= sq_r_r[s] >> 1;
        end
        sq_d_r[s+1] <= sq_d_r[s];
      end
    end
  end

  // prerotation into the right half plane
  function automatic void prerot(input logic signed [17:0] y, input logic signed [17:0] x,
                                 output cval_t xo, output cval_t yo, output ang_t zo);
    cval_t xs, ys;
    xs = cval_t'(x) <<< 14;
    ys = cval_t'(y) <<< 14;
    if (xs < 0) begin
      if (ys >= 0) begin
        xo = ys; yo = -xs; zo = HALF_PI_Q30;
      end else begin
        xo = -ys; yo = xs; zo = -HALF_PI_Q30;
      end
    end else begin
      xo = xs; yo = ys; zo = '0;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      cval_t xo, yo;
      ang_t  zo;
      prerot(sq_d_r[SQ_STEPS].t, $signed({2'b00, sq_r_r[SQ_STEPS][15:0]}), xo, yo, zo);
      cx_r[0][0] <= xo; cy_r[0][0] <= yo; cz_r[0][0] <= zo;
      prerot(sq_d_r[SQ_STEPS].ry, sq_d_r[SQ_STEPS].rx, xo, yo, zo);
      cx_r[1][0] <= xo; cy_r[1][0] <= yo; cz_r[1][0] <= zo;
      prerot(sq_d_r[SQ_STEPS].yy, sq_d_r[SQ_STEPS].yx, xo, yo, zo);
      cx_r[2][0] <= xo; cy_r[2][0] <= yo; cz_r[2][0] <= zo;
      rz_r[0] <= sq_d_r[SQ_STEPS].rzero;
      yz_r[0] <= sq_d_r[SQ_STEPS].yzero;
      // one micro-rotation per stage
      for (int i = 0; i < NSTEPS; i++) begin
        for (int l = 0; l < 3; l++) begin
          if (!cy_r[l][i][CW-1]) begin
            cx_r[l][i+1] <= cx_r[l][i] + (cy_r[l][i] >>> i);
            cy_r[l][i+1] <= cy_r[l][i] - (cx_r[l][i] >>> i);
            cz_r[l][i+1] <= cz_r[l][i] + atan_tab(SHW'(i));
          end else begin
            cx_r[l][i+1] <= cx_r[l][i] - (cy_r[l][i] >>> i);
            cy_r[l][i+1] <= cy_r[l][i] + (cx_r[l][i] >>> i);
            cz_r[l][i+1] <= cz_r[l][i] - atan_tab(SHW'(i));
          end
        end
        rz_r[i+1] <= rz_r[i];
        yz_r[i+1] <= yz_r[i];
      end
    end
  end

  // valid chain and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      if (adv) v_r <= {v_r[NS-2:0], b_valid};
      if (o_valid && o_ready) ov_r <= 1'b0;
      if (adv && v_r[NS-1]) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[NS-1]) begin
      logic signed [16:0] p, r, y;
      p = to_q13(cz_r[0][NSTEPS], PITCH_LIM);
      r = to_q13(cz_r[1][NSTEPS], ANGLE_LIM);
      y = to_q13(cz_r[2][NSTEPS], ANGLE_LIM);
      o_r.pitch <= p[14:0];
      o_r.roll  <= rz_r[NSTEPS] ? 16'sd0 : r[15:0];
      o_r.yaw   <= yz_r[NSTEPS] ? 16'sd0 : y[15:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dcm_to_euler_attitude.sv =====
// Direction cosine matrix to Euler angles. An item enters every cycle while the queue has
// room; it passes the front register, one queue stage, SQ_STEPS + 1 square-root stages,
// one prerotation stage, one stage per CORDIC iteration (at most 32) and the output
// register.
// The front register classifies items, a four-entry queue decouples it from the back
// pipeline, which stalls as a whole only when the output register is held.
// depends on dte_pkg, dte_if, dte_front, dte_queue, dte_back
`default_nettype none
module dcm_to_euler_attitude
  import dte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic [9:0] cfg_wdata,
  dte_in_if.sink     in_ch,
  dte_out_if.source  out_ch
);

  logic [9:0] zb_r;
  logic       fv, fr, qv, qr;
  cls_item_t  fd, qd;

  // dead-band register
  always_ff @(posedge clk) begin
    if (!rst_n) zb_r <= ZB_RESET;
    else if (cfg_we) zb_r <= cfg_wdata;
  end

  dte_front u_front (.clk, .rst_n, .zero_band(zb_r), .in_valid(in_ch.valid),
    .in_ready(in_ch.ready), .in_data(in_ch.data), .f_valid(fv), .f_ready(fr), .f_data(fd));

  dte_queue u_queue (.clk, .rst_n, .w_valid(fv), .w_ready(fr), .w_data(fd),
    .r_valid(qv), .r_ready(qr), .r_data(qd));

  dte_back u_back (.clk, .rst_n, .b_valid(qv), .b_ready(qr), .b_data(qd),
    .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_data(out_ch.data));

endmodule
`default_nettype wire

// ===== tb/sv/dte_tb_pkg.sv =====
// dte_tb_pkg: attitude predictor used by the dcm to euler testbench
// depends on dte_pkg for item types
`default_nettype none
package dte_tb_pkg;
  import dte_pkg::*;

  localparam longint ONE_Q14   = 16384;
  localparam longint HALF_PI   = 64'sd1686629713;
  localparam longint PITCH_MAX = 12868;
  localparam longint ANGLE_MAX = 25736;

  // arctangent of 2^-i in q2.30
  localparam longint ATAN_Q30 [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // vectoring cordic, angle in q2.30
  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    int n;
    n = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    z = 0;
    x = x * ONE_Q14;
    y = y * ONE_Q14;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI;
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_q13(longint z, longint lim);
    longint m;
    longint r;
    m = (z < 0) ? -z : z;
    r = (m + 65536) >>> 17;
    if (r > lim) r = lim;
    return (z < 0) ? -r : r;
  endfunction

  function automatic longint banded_angle(longint y, longint x, logic [9:0] band);
    longint b;
    b = band;
    if (y >= -b && y <= b && x >= -b && x <= b) return 0;
    return round_q13(vector_angle(y, x), ANGLE_MAX);
  endfunction

  function automatic out_item_t predict_attitude(in_item_t m, logic [9:0] band);
    out_item_t r;
    longint t;
    longint c;
    t = m.m21;
    if (t > ONE_Q14) t = ONE_Q14;
    if (t < -ONE_Q14) t = -ONE_Q14;
    c = int_sqrt(ONE_Q14 * ONE_Q14 - t * t);
    r.pitch = 15'(round_q13(vector_angle(t, c), PITCH_MAX));
    r.roll  = 16'(banded_angle(-longint'(m.m20), m.m22, band));
    r.yaw   = 16'(banded_angle(-longint'(m.m01), m.m11, band));
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== tb/sv/tb_dcm_to_euler_attitude.sv =====
// tb_dcm_to_euler_attitude: checks attitude results of the block against a predictor
// depends on dte_pkg, dte_if, dte_tb_pkg and the block rtl
`default_nettype none
module tb_dcm_to_euler_attitude;
  import dte_pkg::*;
  import dte_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    in_item_t  m;
    logic      known;
    out_item_t r;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [9:0] cfg_wdata;
  logic [9:0] band;

  dte_in_if  in_ch ();
  dte_out_if out_ch ();

  dcm_to_euler_attitude u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  out_item_t attitude_q[$];
  int errors;
  int mismatches;
  int cycles = 0;
  bit hold_out;
  stim_row_t rows[$];

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic elem_t rand_elem();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return elem_t'($urandom_range(0, 32768) - 16384);
    if (p < 8) return elem_t'($urandom);
    return elem_t'($urandom_range(0, 6) - 3);
  endfunction

  // valid stays high between back-to-back items and drops only for a gap
  task automatic send_item(in_item_t m, logic known, out_item_t r);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.data <= m;
    in_ch.valid <= 1'b1;
    attitude_q.push_back(known ? r : predict_attitude(m, band));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_empty();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (attitude_q.size() != 0) @(negedge clk);
  endtask

  task automatic drain();
    wait_empty();
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_band(logic [9:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    band = v;
  endtask

  task automatic add_row(elem_t a, elem_t b, elem_t c, elem_t d, elem_t e,
                         logic known, longint p, longint r, longint y);
    stim_row_t s;
    s.m = '{m21: a, m20: b, m22: c, m01: d, m11: e};
    s.known = known;
    s.r = '{pitch: 15'(p), roll: 16'(r), yaw: 16'(y)};
    rows.push_back(s);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (attitude_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected item %p", out_ch.data);
      end else begin
        out_item_t e;
        e = attitude_q.pop_front();
        if (e.pitch !== out_ch.data.pitch || e.roll !== out_ch.data.roll ||
            e.yaw !== out_ch.data.yaw) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch exp %p got %p", e, out_ch.data);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int p;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (120) @(negedge clk);
        hold_out = 0;
      end else begin
        p = $urandom_range(0, 99);
        if (p < 3) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(5, 25)) @(negedge clk);
        end else if (p < 8) begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end else begin
          out_ch.ready <= ($urandom_range(0, 99) < 70);
        end
      end
    end
  end

  // stimulus
  initial begin
    in_item_t m;
    logic [9:0] bands[5];
    bands = '{10'd0, 10'd1023, 10'd37, 10'd3, 10'd200};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    band = ZB_RESET;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    errors = 0;
    mismatches = 0;
    hold_out = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows; all-zero matrix gives zero angles through the dead-band
    add_row(0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(16384, 0, 16384, 0, 16384, 1, PITCH_MAX, 0, 0);
    add_row(32767, 0, 0, 0, 0, 1, PITCH_MAX, 0, 0);
    add_row(-32768, 0, 0, 0, 0, 1, -PITCH_MAX, 0, 0);
    add_row(-16384, 1, -1, -1, 1, 1, -PITCH_MAX, 0, 0);
    add_row(16385, 2, 0, 0, 2, 0, 0, 0, 0);
    add_row(0, -32768, -32768, -32768, -32768, 0, 0, 0, 0);
    add_row(0, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
    add_row(0, 0, -32768, 0, -32768, 0, 0, 0, 0);
    add_row(0, -1, -16384, 1, -16384, 0, 0, 0, 0);
    add_row(0, 1, -16384, -1, -16384, 0, 0, 0, 0);
    add_row(8192, 16384, 0, -16384, 0, 0, 0, 0, 0);
    add_row(-8192, -16384, 0, 16384, 0, 0, 0, 0, 0);
    add_row(11585, 11585, -11585, -11585, 11585, 0, 0, 0, 0);
    add_row(-1, 2, 0, 0, -2, 0, 0, 0, 0);
    add_row(1, -1, -2, 2, 1, 0, 0, 0, 0);
    foreach (rows[i]) send_item(rows[i].m, rows[i].known, rows[i].r);
    drain();

    // band extremes, with edge-of-band arguments
    for (int b = 0; b < 2; b++) begin
      write_band(bands[b]);
      for (int k = 0; k < 6; k++) begin
        m = '{m21: rand_elem(), m20: elem_t'(-int'(band) + k % 2),
              m22: elem_t'(band), m01: elem_t'(band + k / 3), m11: elem_t'(-int'(band))};
        send_item(m, 0, '0);
      end
      drain();
    end

    // random phases over several bands; one long receiver hold mid-phase
    for (int ph = 0; ph < 5; ph++) begin
      write_band(ph == 4 ? 10'($urandom_range(0, 1023)) : bands[ph]);
      for (int n = 0; n < 250; n++) begin
        if (ph == 1 && n == 40) hold_out = 1;
        if (ph == 2 && n == 100) wait_empty();
        m = '{m21: rand_elem(), m20: rand_elem(), m22: rand_elem(),
              m01: rand_elem(), m11: rand_elem()};
        send_item(m, 0, '0);
      end
      drain();
    end

    if (errors == 0 && attitude_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
